/* sv/looped_stream_ring_refill_core_assert.svh */
// ----------------------------------------------------------------------------
// looped stream ring refill assertion macros
// clocked on clk, disabled while arst_n is low
// ----------------------------------------------------------------------------
`ifndef LOOPED_STREAM_RING_REFILL_CORE_ASSERT_SVH
`define LOOPED_STREAM_RING_REFILL_CORE_ASSERT_SVH

// condition must hold at every edge out of reset
`define LSRR_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequence must hold in the cycle after the trigger
`define LSRR_ASSERT_NEXT(lbl, trig, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) else $error(msg);

`endif

/* sv/lsrr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrr_pkg
// shared types, widths and codes of the looped stream ring refill core
// ----------------------------------------------------------------------------
package lsrr_pkg;

	localparam int RING_BYTES  = 8192;
	localparam int DST_W       = $clog2(RING_BYTES);
	localparam int RING_W      = DST_W + 8;
	localparam int REM_W       = RING_W + 1;
	localparam int COUNT_W     = REM_W - 8;
	localparam int SRC_W       = 32;
	localparam int SRC_BYTE_W  = 23;
	localparam int CFG_POS_W   = 31;
	localparam int CFG_W       = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int FC_W        = 9;
	localparam int DELAY_W     = 8;
	localparam int PROD_W      = 48;
	localparam int MAX_CMDS    = 4;
	localparam int CMD_IDX_W   = $clog2(MAX_CMDS);

	localparam logic [REM_W-1:0] RING_Q8   = REM_W'(RING_BYTES) << 8;
	localparam logic [SRC_W-1:0] SRC_START = SRC_W'(RING_BYTES) << 8;
	localparam logic [FC_W-1:0]  FC_START  = '1;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_LEN   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOPED      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_RATE        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_START_DELAY = 3'd4;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_TICK  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_SAT,
		ST_CHECK,
		ST_ROOM,
		ST_PIECE,
		ST_LOAD
	} state_t;

	typedef struct packed {
		logic start;
		logic count_frame;
		logic capture;
		logic mul;
		logic sat;
		logic check;
		logic room;
		logic piece;
		logic load;
	} lsrr_cmd_t;

	typedef struct packed {
		logic delay_done;
		logic final_cmd;
		logic last_slot;
	} lsrr_status_t;

endpackage

/* sv/lsrr_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrr_datapath
// config registers, stream position state, amount and piece arithmetic
// ----------------------------------------------------------------------------
module lsrr_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [lsrr_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [lsrr_pkg::CFG_W-1:0]          cfg_data,
	input  logic [31:0]                         elapsed_ticks,
	input  lsrr_pkg::lsrr_cmd_t                 cmd,
	output lsrr_pkg::lsrr_status_t              status,
	output logic [lsrr_pkg::SRC_BYTE_W-1:0]     src_byte,
	output logic [lsrr_pkg::DST_W-1:0]          dst_byte,
	output logic [lsrr_pkg::COUNT_W-1:0]        byte_count,
	output logic                                fill_zero,
	output logic                                last
);

	// configuration
	logic [lsrr_pkg::CFG_POS_W-1:0] loop_start_q;
	logic [lsrr_pkg::CFG_POS_W-1:0] total_len_q;
	logic                           looped_q;
	logic [31:0]                    rate_q;
	logic [lsrr_pkg::DELAY_W-1:0]   delay_q;

	// stream state
	logic [lsrr_pkg::SRC_W-1:0]     src_pos_q;
	logic [lsrr_pkg::RING_W-1:0]    ring_pos_q;
	logic [lsrr_pkg::FC_W-1:0]      frame_count_q;
	logic                           zero_mode_q;

	// per tick working registers
	logic [31:0]                    elapsed_q;
	logic [lsrr_pkg::PROD_W-1:0]    product_q;
	logic [lsrr_pkg::REM_W-1:0]     rem_q;
	logic [lsrr_pkg::REM_W-1:0]     limit_q;
	logic [lsrr_pkg::REM_W-1:0]     piece_q;
	logic                           final_q;
	logic [lsrr_pkg::CMD_IDX_W-1:0] n_q;

	logic [63:0]                    full_prod;
	logic [lsrr_pkg::REM_W-1:0]     rem_sat;
	logic                           wrap_ok;
	logic                           src_ge_total;
	logic [lsrr_pkg::SRC_W-1:0]     wrap_src;
	logic                           wrap_zero;
	logic [lsrr_pkg::REM_W-1:0]     ring_room;
	logic [lsrr_pkg::SRC_W-1:0]     src_room;
	logic [lsrr_pkg::REM_W-1:0]     limit_next;
	logic                           fits;
	logic [lsrr_pkg::SRC_W-1:0]     src_sum;
	logic                           sum_ge_total;
	logic [8:0]                     frac_sum;
	logic [lsrr_pkg::COUNT_W-1:0]   count_next;
	logic [9:0]                     fc_ext;
	logic [9:0]                     delay_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_start_q <= '0;
			total_len_q  <= '0;
			looped_q     <= 1'b0;
			rate_q       <= '0;
			delay_q      <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				lsrr_pkg::CFG_LOOP_START:  loop_start_q <= cfg_data[lsrr_pkg::CFG_POS_W-1:0];
				lsrr_pkg::CFG_TOTAL_LEN:   total_len_q  <= cfg_data[lsrr_pkg::CFG_POS_W-1:0];
				lsrr_pkg::CFG_LOOPED:      looped_q     <= cfg_data[0];
				lsrr_pkg::CFG_RATE:        rate_q       <= cfg_data;
				lsrr_pkg::CFG_START_DELAY: delay_q      <= cfg_data[lsrr_pkg::DELAY_W-1:0];
				default: ;
			endcase
		end
	end

	// source wrap outcome, shared by the entry check and the update
	always_comb begin
		wrap_ok      = loop_start_q < total_len_q;
		src_ge_total = src_pos_q >= {1'b0, total_len_q};
		wrap_zero    = wrap_ok ? ~looped_q : 1'b1;
		src_sum      = src_pos_q + lsrr_pkg::SRC_W'(piece_q);
		sum_ge_total = src_sum >= {1'b0, total_len_q};
		wrap_src     = {1'b0, loop_start_q};
	end

	assign full_prod = 64'(elapsed_q) * 64'(rate_q);
	assign rem_sat   = (product_q > lsrr_pkg::PROD_W'(lsrr_pkg::RING_Q8)) ?
		lsrr_pkg::RING_Q8 : product_q[lsrr_pkg::REM_W-1:0];

	always_comb begin
		ring_room = lsrr_pkg::RING_Q8 - lsrr_pkg::REM_W'(ring_pos_q);
		src_room  = {1'b0, total_len_q} - src_pos_q;
		if (zero_mode_q) begin
			limit_next = ring_room;
		end else if (src_room < lsrr_pkg::SRC_W'(ring_room)) begin
			limit_next = src_room[lsrr_pkg::REM_W-1:0];
		end else begin
			limit_next = ring_room;
		end
	end

	assign fits       = rem_q <= limit_q;
	assign frac_sum   = {1'b0, src_pos_q[7:0]} + {1'b0, piece_q[7:0]};
	assign count_next = piece_q[lsrr_pkg::REM_W-1:8] + lsrr_pkg::COUNT_W'(frac_sum[8]);

	assign fc_ext    = {frame_count_q[lsrr_pkg::FC_W-1], frame_count_q};
	assign delay_ext = {2'b00, delay_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_pos_q     <= lsrr_pkg::SRC_START;
			ring_pos_q    <= '0;
			frame_count_q <= lsrr_pkg::FC_START;
			zero_mode_q   <= 1'b0;
			n_q           <= '0;
			final_q       <= 1'b0;
		end else begin
			if (cmd.start) begin
				src_pos_q     <= lsrr_pkg::SRC_START;
				ring_pos_q    <= '0;
				frame_count_q <= lsrr_pkg::FC_START;
				zero_mode_q   <= 1'b0;
			end else if (cmd.count_frame) begin
				frame_count_q <= frame_count_q + 1'b1;
			end else if (cmd.check) begin
				// source already past its end on entry
				if (!zero_mode_q && src_ge_total) begin
					if (wrap_ok) begin
						src_pos_q <= wrap_src;
					end
					zero_mode_q <= wrap_zero;
				end
			end else if (cmd.load) begin
				if (!zero_mode_q) begin
					if (sum_ge_total) begin
						src_pos_q   <= wrap_ok ? wrap_src : src_sum;
						zero_mode_q <= wrap_zero;
					end else begin
						src_pos_q <= src_sum;
					end
				end
				ring_pos_q <= ring_pos_q + piece_q[lsrr_pkg::RING_W-1:0];
			end
			if (cmd.sat) begin
				n_q <= '0;
			end else if (cmd.load) begin
				n_q <= n_q + 1'b1;
			end
			if (cmd.piece) begin
				final_q <= fits || (n_q == lsrr_pkg::CMD_IDX_W'(lsrr_pkg::MAX_CMDS - 1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			elapsed_q <= elapsed_ticks;
		end
		if (cmd.mul) begin
			product_q <= full_prod[63:16];
		end
		if (cmd.sat) begin
			rem_q <= rem_sat;
		end else if (cmd.load) begin
			rem_q <= rem_q - piece_q;
		end
		if (cmd.room) begin
			limit_q <= limit_next;
		end
		if (cmd.piece) begin
			piece_q <= fits ? rem_q : limit_q;
		end
		if (cmd.load) begin
			src_byte   <= zero_mode_q ? '0 : src_pos_q[lsrr_pkg::SRC_BYTE_W+7:8];
			dst_byte   <= ring_pos_q[lsrr_pkg::RING_W-1:8];
			byte_count <= count_next;
			fill_zero  <= zero_mode_q;
			last       <= final_q;
		end
	end

	assign status.delay_done = $signed(fc_ext) >= $signed(delay_ext);
	assign status.final_cmd  = final_q;
	assign status.last_slot  = n_q == lsrr_pkg::CMD_IDX_W'(lsrr_pkg::MAX_CMDS - 1);

endmodule

/* sv/lsrr_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsrr_ctrl
// sequencer for tick handling and the output register valid
// ----------------------------------------------------------------------------
`include "looped_stream_ring_refill_core_assert.svh"

module lsrr_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	input  logic                   mode,
	input  logic                   out_stall,
	input  lsrr_pkg::lsrr_status_t status,
	output logic                   in_stall,
	output logic                   out_valid,
	output lsrr_pkg::lsrr_cmd_t    cmd
);

	lsrr_pkg::state_t state_q;
	lsrr_pkg::state_t state_next;
	logic             out_valid_q;
	logic             can_load;

	assign can_load = !out_valid_q || !out_stall;

	always_comb begin
		state_next = state_q;
		case (state_q)
			lsrr_pkg::ST_IDLE: begin
				if (in_valid && mode == lsrr_pkg::MODE_TICK && status.delay_done) begin
					state_next = lsrr_pkg::ST_MUL;
				end
			end
			lsrr_pkg::ST_MUL:   state_next = lsrr_pkg::ST_SAT;
			lsrr_pkg::ST_SAT:   state_next = lsrr_pkg::ST_CHECK;
			lsrr_pkg::ST_CHECK: state_next = lsrr_pkg::ST_ROOM;
			lsrr_pkg::ST_ROOM:  state_next = lsrr_pkg::ST_PIECE;
			lsrr_pkg::ST_PIECE: state_next = lsrr_pkg::ST_LOAD;
			lsrr_pkg::ST_LOAD: begin
				if (can_load) begin
					state_next = status.final_cmd ? lsrr_pkg::ST_IDLE : lsrr_pkg::ST_CHECK;
				end
			end
			default: state_next = lsrr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			lsrr_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (mode == lsrr_pkg::MODE_START) begin
						cmd.start = 1'b1;
					end else if (!status.delay_done) begin
						cmd.count_frame = 1'b1;
					end else begin
						cmd.capture = 1'b1;
					end
				end
			end
			lsrr_pkg::ST_MUL:   cmd.mul   = 1'b1;
			lsrr_pkg::ST_SAT:   cmd.sat   = 1'b1;
			lsrr_pkg::ST_CHECK: cmd.check = 1'b1;
			lsrr_pkg::ST_ROOM:  cmd.room  = 1'b1;
			lsrr_pkg::ST_PIECE: cmd.piece = 1'b1;
			lsrr_pkg::ST_LOAD:  cmd.load  = can_load;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lsrr_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`LSRR_ASSERT_ALWAYS(a_load_free, !cmd.load || !out_valid_q || !out_stall, "load over a held result")
	`LSRR_ASSERT_NEXT(a_final_idle, cmd.load && status.final_cmd, state_q == lsrr_pkg::ST_IDLE, "final command did not end the tick")
	`LSRR_ASSERT_NEXT(a_fourth_final, cmd.piece && status.last_slot, status.final_cmd, "fourth command not final")
	`LSRR_ASSERT_NEXT(a_load_valid, cmd.load, out_valid, "loaded result not shown")

endmodule

/* sv/looped_stream_ring_refill_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// looped_stream_ring_refill_core
// turns timer ticks into copy/clear commands refilling a playback ring
// buffer from a looping pcm source
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  mode, elapsed_ticks
//  out      out_valid / out_stall src_byte, dst_byte, byte_count, fill_zero, last
//  cfg      cfg_we               cfg_index, cfg_data
//
//  a start item or a tick still in its startup delay is taken without leaving idle
//  a copying tick steps through capture, multiply and saturate, then the
//  per command check / room / piece / update sequence over one shared datapath
//  the last command sits in the output register while the next item is taken
//  out_stall only holds the command sequence when a new command is ready
//  arst_n clears control and stream state; positions restart as after a start item
// ----------------------------------------------------------------------------
module looped_stream_ring_refill_core (
	input  logic                               clk,
	input  logic                               arst_n,
	// item input
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               mode,
	input  logic [31:0]                        elapsed_ticks,
	// command output
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [lsrr_pkg::SRC_BYTE_W-1:0]    src_byte,
	output logic [lsrr_pkg::DST_W-1:0]         dst_byte,
	output logic [lsrr_pkg::COUNT_W-1:0]       byte_count,
	output logic                               fill_zero,
	output logic                               last,
	// register writes
	input  logic                               cfg_we,
	input  logic [lsrr_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lsrr_pkg::CFG_W-1:0]         cfg_data
);

	// controller to datapath commands and back
	lsrr_pkg::lsrr_cmd_t    cmd;
	lsrr_pkg::lsrr_status_t status;

	// sequencer: start, delay count, multiply, saturate, then per command steps
	lsrr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.mode      (mode),
		.out_stall (out_stall),
		.status    (status),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// positions, amount, room and piece arithmetic, output register
	lsrr_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.elapsed_ticks (elapsed_ticks),
		.cmd           (cmd),
		.status        (status),
		.src_byte      (src_byte),
		.dst_byte      (dst_byte),
		.byte_count    (byte_count),
		.fill_zero     (fill_zero),
		.last          (last)
	);

endmodule
